@@ sv/dcst_pkg.sv @@
// ----------------------------------------------------------------------------
// dcst_pkg: shared types and codes for the deadline commitment slot table
// Mode, state and status codes and the request record passed down the cells.
// ----------------------------------------------------------------------------
package dcst_pkg;

  localparam logic [2:0] MODE_ACCEPT  = 3'd0;
  localparam logic [2:0] MODE_FULFIL  = 3'd1;
  localparam logic [2:0] MODE_RELEASE = 3'd2;
  localparam logic [2:0] MODE_READ    = 3'd3;
  localparam logic [2:0] MODE_COUNT   = 3'd4;

  localparam logic [2:0] ST_FREE      = 3'd0;
  localparam logic [2:0] ST_COMMITTED = 3'd1;
  localparam logic [2:0] ST_FULFILLED = 3'd2;
  localparam logic [2:0] ST_RELEASED  = 3'd3;
  localparam logic [2:0] ST_BROKEN    = 3'd4;

  localparam logic [2:0] RS_OK        = 3'd0;
  localparam logic [2:0] RS_NO_GUAR   = 3'd1;
  localparam logic [2:0] RS_NOT_READY = 3'd2;
  localparam logic [2:0] RS_FULL      = 3'd3;
  localparam logic [2:0] RS_BAD_SLOT  = 3'd4;
  localparam logic [2:0] RS_LATE      = 3'd5;
  localparam logic [2:0] RS_BAD_CAUSE = 3'd6;

  localparam logic [2:0] CAUSE_BATTERY = 3'd1;
  localparam logic [2:0] CAUSE_ROUTE   = 3'd2;
  localparam logic [2:0] CAUSE_REST    = 3'd3;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 216;

  // request travelling down the chain, with the answer it collects
  typedef struct packed {
    logic        vld;
    logic [2:0]  mode;
    logic [62:0] now;
    logic [7:0]  idx;
    logic [3:0]  kind;
    logic [63:0] span;
    logic [2:0]  cause;
    logic [2:0]  status;
    logic        taken;
    logic [5:0]  slot;
    logic [2:0]  rd_state;
    logic [3:0]  rd_kind;
    logic [62:0] rd_acc;
    logic [62:0] rd_close;
    logic [63:0] rd_span;
    logic [2:0]  rd_cause;
    logic [6:0]  count;
  } dcst_req_t;

endpackage

@@ sv/deadline_commitment_slot_table.sv @@
// ----------------------------------------------------------------------------
// deadline_commitment_slot_table: deadline-tracked commitment slots
// Commands walk a row of slot cells; one answer comes back per command.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake               | payload
//  s_axis    | in  | s_tvalid/s_tready       | s_tuser mode, s_tdata fields
//  m_axis    | out | m_tvalid/m_tready       | m_tdata result fields
//  apb       | in  | psel/penable/pwrite     | core_ready, written when paddr[2]==0
//
// A command that walks the cells is launched into chain[0] at the accepting
// edge, passes through the register of each slot cell in turn, and is then
// captured in out_data; commands rejected up front answer without the cells.
// One command is in flight; s_tready is low until its answer is taken.
// Synchronous reset frees every slot and clears core_ready.
module deadline_commitment_slot_table #(
  parameter int SLOT_COUNT = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // now_time[62:0], slot_index[70:63], kind_in[74:71], allowed_span[138:75],
  // capacity_ok[139], cause_in[142:140], zero pad
  input  logic [dcst_pkg::IN_DATA_W-1:0]    s_tdata,
  // mode[2:0]
  input  logic [2:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status[2:0], slot_out[8:3], state_out[11:9], kind_out[15:12],
  // accepted_at[78:16], closed_at[141:79], span_out[205:142],
  // cause_out[208:206], free_count[215:209]
  output logic [dcst_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import dcst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_OUT  = 3'b100
  } fsm_t;

  fsm_t        fsm, fsm_next;
  logic        core_ready;
  dcst_req_t   chain [SLOT_COUNT+1];
  dcst_req_t   launch_next;
  logic [OUT_DATA_W-1:0] out_data, out_next;

  logic [2:0]  in_mode, in_cause;
  logic [62:0] in_now;
  logic [7:0]  in_idx;
  logic [3:0]  in_kind;
  logic [63:0] in_span;
  logic        in_cap, idx_bad, cause_bad, take;
  logic [2:0]  early_status;
  logic        early;
  dcst_req_t   fin;

  assign in_mode  = s_tuser;
  assign in_now   = s_tdata[62:0];
  assign in_idx   = s_tdata[70:63];
  assign in_kind  = s_tdata[74:71];
  assign in_span  = s_tdata[138:75];
  assign in_cap   = s_tdata[139];
  assign in_cause = s_tdata[142:140];

  assign pready = 1'b1;
  assign prdata = {31'b0, core_ready};

  always_ff @(posedge clk) begin
    if (rst) core_ready <= 1'b0;
    else if (psel && penable && pwrite && !paddr[2]) core_ready <= pwdata[0];
  end

  assign s_tready = fsm == S_IDLE;
  assign take     = s_tvalid && s_tready;
  assign m_tvalid = fsm == S_OUT;
  assign m_tdata  = out_data;

  assign idx_bad   = {1'b0, in_idx} >= 9'(SLOT_COUNT);
  assign cause_bad = !(in_cause == CAUSE_BATTERY || in_cause == CAUSE_ROUTE ||
                       in_cause == CAUSE_REST);

  // requests settled without visiting the slots
  always_comb begin
    early        = 1'b0;
    early_status = RS_OK;
    case (in_mode)
      MODE_ACCEPT: begin
        if (!in_cap) begin
          early = 1'b1; early_status = RS_NO_GUAR;
        end else if (!core_ready) begin
          early = 1'b1; early_status = RS_NOT_READY;
        end
      end
      MODE_FULFIL, MODE_READ: begin
        if (idx_bad) begin
          early = 1'b1; early_status = RS_BAD_SLOT;
        end
      end
      MODE_RELEASE: begin
        if (idx_bad) begin
          early = 1'b1; early_status = RS_BAD_SLOT;
        end else if (cause_bad) begin
          early = 1'b1; early_status = RS_BAD_CAUSE;
        end
      end
      MODE_COUNT: ;
      default: early = 1'b1;
    endcase
  end

  always_comb begin
    launch_next       = '0;
    launch_next.vld   = take && !early;
    launch_next.mode  = in_mode;
    launch_next.now   = in_now;
    launch_next.idx   = in_idx;
    launch_next.kind  = in_kind;
    launch_next.span  = in_span;
    launch_next.cause = in_cause;
  end

  always_ff @(posedge clk) begin
    if (rst) chain[0] <= '0;
    else     chain[0] <= launch_next;
  end

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    dcst_cell #(.CELL_ID(i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .req_in (chain[i]),
      .req_out(chain[i+1])
    );
  end

  assign fin = chain[SLOT_COUNT];

  always_comb begin
    fsm_next = fsm;
    out_next = out_data;
    case (fsm)
      S_IDLE: begin
        if (take) begin
          if (early) begin
            out_next      = '0;
            out_next[2:0] = early_status;
            fsm_next      = S_OUT;
          end else begin
            fsm_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (fin.vld) begin
          out_next = '0;
          case (fin.mode)
            MODE_ACCEPT: begin
              out_next[2:0] = fin.taken ? RS_OK : RS_FULL;
              out_next[8:3] = fin.taken ? fin.slot : 6'd0;
            end
            MODE_READ: begin
              out_next[2:0]     = RS_OK;
              out_next[11:9]    = fin.rd_state;
              out_next[15:12]   = fin.rd_kind;
              out_next[78:16]   = fin.rd_acc;
              out_next[141:79]  = fin.rd_close;
              out_next[205:142] = fin.rd_span;
              out_next[208:206] = fin.rd_cause;
            end
            MODE_COUNT: begin
              out_next[2:0]     = RS_OK;
              out_next[215:209] = fin.count;
            end
            default: out_next[2:0] = fin.status;
          endcase
          fsm_next = S_OUT;
        end
      end
      S_OUT: begin
        if (m_tready) fsm_next = S_IDLE;
      end
      default: fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) fsm <= S_IDLE;
    else     fsm <= fsm_next;
  end

  always_ff @(posedge clk) begin
    out_data <= out_next;
  end

endmodule

@@ sv/dcst_cell.sv @@
// ----------------------------------------------------------------------------
// dcst_cell: one commitment slot
// Holds one slot and updates it as a request passes; forwards the request.
// ----------------------------------------------------------------------------
module dcst_cell #(
  parameter int CELL_ID = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  dcst_pkg::dcst_req_t req_in,
  output dcst_pkg::dcst_req_t req_out
);
  import dcst_pkg::*;

  logic [2:0]  state_q, state_next;
  logic [3:0]  kind_q, kind_next;
  logic [62:0] acc_q, acc_next;
  logic [63:0] span_q, span_next;
  logic [62:0] close_q, close_next;
  logic [2:0]  cause_q, cause_next;
  dcst_req_t   req_next;

  logic [63:0] deadline;
  logic        overdue, hit, expire_en;
  logic [2:0]  eff_state;
  logic [62:0] eff_close;

  assign deadline  = {1'b0, acc_q} + span_q;
  assign overdue   = (state_q == ST_COMMITTED) && ({1'b0, req_in.now} > deadline);
  assign hit       = req_in.idx == 8'(CELL_ID);
  assign expire_en = req_in.vld && overdue &&
                     (req_in.mode == MODE_ACCEPT || req_in.mode == MODE_READ ||
                      req_in.mode == MODE_COUNT);
  assign eff_state = expire_en ? ST_BROKEN : state_q;
  assign eff_close = expire_en ? req_in.now : close_q;

  always_comb begin
    state_next = eff_state;
    close_next = eff_close;
    kind_next  = kind_q;
    acc_next   = acc_q;
    span_next  = span_q;
    cause_next = cause_q;
    req_next   = req_in;
    if (req_in.vld) begin
      case (req_in.mode)
        MODE_ACCEPT: begin
          if (!req_in.taken && eff_state != ST_COMMITTED) begin
            state_next     = ST_COMMITTED;
            kind_next      = req_in.kind;
            acc_next       = req_in.now;
            span_next      = req_in.span;
            close_next     = '0;
            cause_next     = '0;
            req_next.taken = 1'b1;
            req_next.slot  = 6'(CELL_ID);
          end
        end
        MODE_FULFIL: begin
          if (hit) begin
            if (state_q == ST_COMMITTED) begin
              close_next      = req_in.now;
              state_next      = overdue ? ST_BROKEN : ST_FULFILLED;
              req_next.status = overdue ? RS_LATE : RS_OK;
            end else begin
              req_next.status = RS_BAD_SLOT;
            end
          end
        end
        MODE_RELEASE: begin
          if (hit) begin
            if (state_q == ST_COMMITTED) begin
              state_next = ST_RELEASED;
              cause_next = req_in.cause;
              close_next = req_in.now;
            end else begin
              req_next.status = RS_BAD_SLOT;
            end
          end
        end
        MODE_READ: begin
          if (hit) begin
            req_next.rd_state = eff_state;
            req_next.rd_kind  = kind_q;
            req_next.rd_acc   = acc_q;
            req_next.rd_close = eff_close;
            req_next.rd_span  = span_q;
            req_next.rd_cause = cause_q;
          end
        end
        MODE_COUNT: begin
          if (eff_state != ST_COMMITTED) req_next.count = req_in.count + 7'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= ST_FREE;
      kind_q  <= '0;
      acc_q   <= '0;
      span_q  <= '0;
      close_q <= '0;
      cause_q <= '0;
      req_out <= '0;
    end else begin
      state_q <= state_next;
      kind_q  <= kind_next;
      acc_q   <= acc_next;
      span_q  <= span_next;
      close_q <= close_next;
      cause_q <= cause_next;
      req_out <= req_next;
    end
  end

endmodule
